// ----- design/lfg_pkg.sv -----
// Shared types, constants and helper functions of the fuel gauge.
`timescale 1ns / 1ps
package lfg_pkg;

	// Display and timing constants
	localparam int LED_COUNT      = 8;
	localparam int FLASH_TICKS    = 10;
	localparam int GPS_TIMEOUT_MS = 2000;
	localparam int TICK_W         = $clog2(FLASH_TICKS + 1);

	// Voltage curve and state of charge scale
	localparam int CURVE_POINTS   = 13;
	localparam int IDX_W          = $clog2(CURVE_POINTS);
	localparam int SOC_ONE        = 10000;
	localparam int SOC_RED_MAX    = 2000;
	localparam int SOC_YELLOW_MAX = 4000;
	localparam int SOC_W          = 14;
	localparam int HYST_CMS       = 50;
	localparam int SPEED_MAX_CMS  = 10000;

	// Datapath widths of the segment interpolation
	localparam int SPAN_W = 10;               // cells * widest segment step, at most 600
	localparam int QUO_W  = 11;               // segment soc step, at most 1500
	localparam int PROD_W = SPAN_W + QUO_W;   // offset times soc step

	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic REG_CELL_COUNT = 1'b0;
	localparam logic REG_SPEED_OFF  = 1'b1;

	// Colour codes
	localparam logic [1:0] COL_OFF    = 2'd0;
	localparam logic [1:0] COL_RED    = 2'd1;
	localparam logic [1:0] COL_YELLOW = 2'd2;
	localparam logic [1:0] COL_GREEN  = 2'd3;

	localparam logic [3:0] LIT_FULL = 4'(LED_COUNT);

	localparam logic [12:0] CURVE_MV [CURVE_POINTS] = '{
		13'd3400, 13'd3500, 13'd3600, 13'd3700, 13'd3750, 13'd3800, 13'd3850,
		13'd3900, 13'd3950, 13'd4000, 13'd4100, 13'd4150, 13'd4200
	};
	localparam logic [SOC_W-1:0] CURVE_SOC [CURVE_POINTS] = '{
		14'd0, 14'd200, 14'd500, 14'd1500, 14'd2500, 14'd4000, 14'd5000,
		14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd9500, 14'd10000
	};

	// One queued display word: either a finished result or a curve lookup
	typedef struct packed {
		logic        is_curve;
		logic [3:0]  lit;
		logic [1:0]  colour;
		logic [15:0] pack_mv;
		logic [2:0]  cells;
	} entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEARCH,
		B_MUL,
		B_DIV,
		B_DONE
	} back_state_t;

	// Pack voltage of a curve point for the given cell count
	function automatic logic [15:0] cell_mv(input logic [2:0] cells, input logic [IDX_W-1:0] idx);
		logic [15:0] r;
		r = '0;
		if (32'(idx) < CURVE_POINTS) begin
			r = 16'(cells) * 16'(CURVE_MV[idx]);
		end
		return r;
	endfunction

	function automatic logic [SOC_W-1:0] curve_soc(input logic [IDX_W-1:0] idx);
		logic [SOC_W-1:0] r;
		r = '0;
		if (32'(idx) < CURVE_POINTS) begin
			r = CURVE_SOC[idx];
		end
		return r;
	endfunction

endpackage

// ----- design/lfg_front.sv -----
// Front end: accepts frames, tracks blanking and flashing, classifies the display.
`timescale 1ns / 1ps
module lfg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         pack_mv,
	input  logic                gps_valid,
	input  logic [15:0]         gps_age_ms,
	input  logic [15:0]         ground_speed_cms,
	input  logic [2:0]          cell_count,
	input  logic [13:0]         speed_off_cms,
	input  logic                q_full,
	output logic                q_push,
	output lfg_pkg::entry_t     q_wdata
);
	import lfg_pkg::*;

	logic              blanked_q, sent_q, flash_q;
	logic [TICK_W-1:0] ticks_q;

	logic              accept, gps_ok, blanked_nx, sent_nx, flash_nx, emit;
	logic [TICK_W-1:0] ticks_mid, ticks_nx;
	logic [2:0]        cells;
	logic [13:0]       thr;
	logic [16:0]       speed_hyst;
	logic              is_full, is_empty;
	entry_t            ent;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Clamp configuration to its usable range
	assign cells = (cell_count < 3'd2) ? 3'd2 : ((cell_count > 3'd6) ? 3'd6 : cell_count);
	assign thr   = (speed_off_cms > 14'(SPEED_MAX_CMS)) ? 14'(SPEED_MAX_CMS) : speed_off_cms;

	// Drop stale GPS reports
	assign gps_ok     = gps_valid && !(gps_age_ms > 16'(GPS_TIMEOUT_MS));
	assign speed_hyst = 17'(ground_speed_cms) + 17'(HYST_CMS);

	// Blanking with hysteresis
	always_comb begin
		blanked_nx = 1'b0;
		if (thr != '0 && gps_ok) begin
			blanked_nx = blanked_q;
			if (!blanked_q && ground_speed_cms > 16'(thr)) begin
				blanked_nx = 1'b1;
			end else if (blanked_q && speed_hyst < 17'(thr)) begin
				blanked_nx = 1'b0;
			end
		end
	end

	assign is_full  = pack_mv >= cell_mv(cells, IDX_W'(CURVE_POINTS - 1));
	assign is_empty = pack_mv <= cell_mv(cells, '0);

	// Classify the frame and advance the flash timer
	always_comb begin
		sent_nx   = 1'b0;
		emit      = 1'b1;
		flash_nx  = flash_q;
		ticks_mid = ticks_q;
		ent.is_curve = 1'b0;
		ent.lit      = '0;
		ent.colour   = COL_OFF;
		ent.pack_mv  = pack_mv;
		ent.cells    = cells;
		if (blanked_nx) begin
			sent_nx = 1'b1;
			emit    = !sent_q;
		end else if (is_full) begin
			ent.lit    = LIT_FULL;
			ent.colour = COL_GREEN;
		end else if (is_empty) begin
			if (ticks_q >= TICK_W'(FLASH_TICKS)) begin
				ticks_mid = '0;
				flash_nx  = !flash_q;
			end
			if (flash_nx) begin
				ent.lit    = LIT_FULL;
				ent.colour = COL_RED;
			end
		end else begin
			ent.is_curve = 1'b1;
		end
		ticks_nx = (ticks_mid < TICK_W'(FLASH_TICKS)) ? ticks_mid + 1'b1 : ticks_mid;
	end

	assign q_push  = accept && emit;
	assign q_wdata = ent;

	// Update frame state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blanked_q <= 1'b0;
			sent_q    <= 1'b0;
			flash_q   <= 1'b1;
			ticks_q   <= '0;
		end else if (accept) begin
			blanked_q <= blanked_nx;
			sent_q    <= sent_nx;
			flash_q   <= flash_nx;
			ticks_q   <= ticks_nx;
		end
	end

endmodule

// ----- design/lfg_queue.sv -----
// Short queue between the front end and the curve engine.
`timescale 1ns / 1ps
module lfg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lfg_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output lfg_pkg::entry_t head
);
	import lfg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_q];

	// Store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/lfg_back.sv -----
// Back end: curve segment search, interpolation divider and output register.
`timescale 1ns / 1ps
module lfg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  lfg_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      lit_count,
	output logic [1:0]      colour
);
	import lfg_pkg::*;

	localparam int CNT_W  = $clog2(QUO_W);
	localparam int SOCL_W = $clog2(SOC_ONE * LED_COUNT + 1);
	localparam int LCNT_W = $clog2(LED_COUNT + 1);

	back_state_t       state_q, state_nx;
	logic [15:0]       pack_q;
	logic [2:0]        cells_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SPAN_W-1:0] span_q;
	logic [SOC_W-1:0]  socb_q;
	logic [SPAN_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [3:0]        lit_q;
	logic [1:0]        colour_q;

	logic              out_free, hit, load_direct, load_curve, start, div_last;
	logic [15:0]       base_mv, top_mv, off_full;
	logic [SPAN_W-1:0] off, span;
	logic [QUO_W-1:0]  dsoc;
	logic [PROD_W-1:0] prod;
	logic [SPAN_W:0]   trial;
	logic              ge;
	logic [SOC_W-1:0]  soc;
	logic [SOCL_W-1:0] soc_l;
	logic [LCNT_W-1:0] above;
	logic [3:0]        lit_c;
	logic [1:0]        colour_c;

	assign out_free = !out_valid_q || out_ready;
	assign hit      = pack_q <= cell_mv(cells_q, idx_q);
	assign div_last = cnt_q == CNT_W'(QUO_W - 1);

	// Segment offset, span and scaled soc step
	assign base_mv  = cell_mv(cells_q, idx_q - 1'b1);
	assign top_mv   = cell_mv(cells_q, idx_q);
	assign off_full = pack_q - base_mv;
	assign off      = off_full[SPAN_W-1:0];
	assign span     = SPAN_W'(top_mv - base_mv);
	assign dsoc     = QUO_W'(curve_soc(idx_q) - curve_soc(idx_q - 1'b1));
	assign prod     = PROD_W'(off) * PROD_W'(dsoc);

	// Restoring divide step
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, span_q};

	// Bar length and colour from the interpolated soc
	always_comb begin
		soc   = socb_q + SOC_W'(quo_q);
		soc_l = SOCL_W'(soc) * SOCL_W'(LED_COUNT);
		above = '0;
		for (int k = 1; k < LED_COUNT; k++) begin
			if (soc_l > SOCL_W'(k * SOC_ONE)) begin
				above = above + 1'b1;
			end
		end
		lit_c = 4'(above + 1'b1);
		if (soc <= SOC_W'(SOC_RED_MAX)) begin
			colour_c = COL_RED;
		end else if (soc <= SOC_W'(SOC_YELLOW_MAX)) begin
			colour_c = COL_YELLOW;
		end else begin
			colour_c = COL_GREEN;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid && head.is_curve) begin
					state_nx = B_SEARCH;
				end
			end
			B_SEARCH: begin
				if (hit) begin
					state_nx = B_MUL;
				end
			end
			B_MUL: state_nx = B_DIV;
			B_DIV: begin
				if (div_last) begin
					state_nx = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		load_direct = 1'b0;
		load_curve  = 1'b0;
		start       = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				load_direct = head_valid && !head.is_curve && out_free;
				start       = head_valid && head.is_curve;
			end
			B_DONE: load_curve = out_free;
			default: begin
			end
		endcase
	end

	assign pop = load_direct || start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Curve datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				pack_q  <= head.pack_mv;
				cells_q <= head.cells;
				idx_q   <= IDX_W'(1);
			end
			B_SEARCH: begin
				if (!hit) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			B_MUL: begin
				span_q <= span;
				socb_q <= curve_soc(idx_q - 1'b1);
				rem_q  <= prod[PROD_W-1:QUO_W];
				quo_q  <= prod[QUO_W-1:0];
				cnt_q  <= '0;
			end
			B_DIV: begin
				rem_q <= ge ? SPAN_W'(trial - {1'b0, span_q}) : trial[SPAN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_curve) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			lit_q    <= head.lit;
			colour_q <= head.colour;
		end else if (load_curve) begin
			lit_q    <= lit_c;
			colour_q <= colour_c;
		end
	end

	assign out_valid = out_valid_q;
	assign lit_count = lit_q;
	assign colour    = colour_q;

endmodule

// ----- design/lipo_led_fuel_gauge.sv -----
// Top level of the LiPo LED fuel gauge: configuration registers, front end, queue, back end.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------------
//  input    | in_valid / in_ready       | pack_mv, gps_valid, gps_age_ms, ground_speed_cms
//  output   | out_valid / out_ready     | lit_count, colour
//  config   | cfg_we                    | cfg_index, cfg_wdata
//
//  Full and empty frames, and the first frame of a blanking run, pass the queue and are
//  loaded into the output register when the back end is idle and that register is free.
//  Curve frames pass the back end states in order: the word is taken in idle, the segment
//  search checks 1 to 12 curve points (one curve point a cycle), a multiply state,
//  11 divider steps, then the output load once the output register is free.
//  The front end keeps taking words while the two-entry queue has room.
//  Reset clears blanking, flash timer and queue state and sets the flash phase on; no clearing pass is needed.
//  A stalled output holds its word; the back end waits on it before loading the next.
`timescale 1ns / 1ps
module lipo_led_fuel_gauge (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pack_mv,
	input  logic        gps_valid,
	input  logic [15:0] gps_age_ms,
	input  logic [15:0] ground_speed_cms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  lit_count,
	output logic [1:0]  colour,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [13:0] cfg_wdata
);
	import lfg_pkg::*;

	logic [2:0]  cell_count_q;
	logic [13:0] speed_off_q;

	logic   q_push, q_full, q_pop, q_valid;
	entry_t q_wdata, q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= 3'd3;
			speed_off_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_COUNT: cell_count_q <= cfg_wdata[2:0];
				REG_SPEED_OFF:  speed_off_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	lfg_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pack_mv          (pack_mv),
		.gps_valid        (gps_valid),
		.gps_age_ms       (gps_age_ms),
		.ground_speed_cms (ground_speed_cms),
		.cell_count       (cell_count_q),
		.speed_off_cms    (speed_off_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_wdata          (q_wdata)
	);

	lfg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wdata      (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	lfg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.lit_count  (lit_count),
		.colour     (colour)
	);

	// Never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue overflow");

	// Never read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");

	// A dark display lights nothing
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && colour == COL_OFF) |-> lit_count == '0) else $error("lit while off");

endmodule
